// File: hw/rtl/rlc_pkg.sv
// Shared types, codes and keyword tables for the rover command line checker.
package rlc_pkg;

   localparam int CH_WIDTH     = 8;
   localparam int STATUS_WIDTH = 2;
   localparam int CMD_WIDTH    = 3;
   localparam int VALUE_WIDTH  = 16;

   localparam int KW_NUM       = 6;
   localparam int KW_MAXLEN    = 14;
   localparam int KW_IDX_WIDTH = 3;
   localparam int LC_WIDTH     = 4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_SYNTAX = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE  = 2'd2;

   localparam logic [CMD_WIDTH-1:0] CMD_WHEELS     = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_ARM_TURN   = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_MOVE       = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_ARM_EXTEND = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_TILT       = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_PHOTO      = 3'd5;

   // range limits on the magnitude; all fit in 10 bits
   localparam logic [9:0] LIM_WHEELS     = 10'd70;
   localparam logic [9:0] LIM_ARM_TURN   = 10'd360;
   localparam logic [9:0] LIM_ARM_EXTEND = 10'd100;
   localparam logic [9:0] LIM_TILT       = 10'd45;

   localparam logic [CH_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_WIDTH-1:0] CH_POINT = 8'h2E;

   // keywords right-justified: first letter sits in the highest used byte
   localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_NUM] = '{
      "girarRuedas", "girarBrazo", "mover",
      "extiendeBrazo", "inclinaCamara", "tomarFoto"
   };
   localparam logic [LC_WIDTH-1:0] KW_LEN [KW_NUM] = '{
      4'd11, 4'd10, 4'd5, 4'd13, 4'd13, 4'd9
   };

   function automatic logic [CH_WIDTH-1:0] kw_letter(input logic [KW_IDX_WIDTH-1:0] k,
                                                     input logic [LC_WIDTH-1:0] idx);
      int base;
      base = (int'(KW_LEN[k]) - 1 - int'(idx)) * 8;
      if (idx < KW_LEN[k])
         return KW_TEXT[k][base +: 8];
      else
         return '0;
   endfunction

   function automatic logic is_letter(input logic [CH_WIDTH-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [CH_WIDTH-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

// File: hw/rtl/rlc_req_if.sv
// Character channel: one character or one end-of-line marker per transfer.
interface rlc_req_if;
   logic                          valid;
   logic                          ready;
   logic [rlc_pkg::CH_WIDTH-1:0]  ch;
   logic                          line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink   (input valid, input ch, input line_end, output ready);
endinterface

// File: hw/rtl/rlc_rsp_if.sv
// Verdict channel: one line verdict per transfer.
interface rlc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rlc_pkg::STATUS_WIDTH-1:0]  status;
   logic [rlc_pkg::CMD_WIDTH-1:0]     command;
   logic                              param_negative;
   logic [rlc_pkg::VALUE_WIDTH-1:0]   param_integer;
   logic                              param_has_fraction;
   logic [rlc_pkg::VALUE_WIDTH-1:0]   line_number;

   modport source (output valid, output status, output command, output param_negative,
                   output param_integer, output param_has_fraction, output line_number,
                   input ready);
   modport sink   (input valid, input status, input command, input param_negative,
                   input param_integer, input param_has_fraction, input line_number,
                   output ready);
endinterface

// File: hw/rtl/rover_command_line_checker.sv
// Rover command line checker: parses "keyword space signed-decimal" lines.
//
// req_chan carries one ASCII character per transfer, or an end-of-line marker
// (line_end high, ch ignored). Characters produce no output. Each marker
// produces one verdict on rsp_chan: status (syntax error, accepted, out of
// range), command code, sign, saturated integer magnitude, nonzero-fraction
// flag and a line number that counts markers from 1 and wraps.
//
// Throughput: one transfer per cycle on req_chan. Each character updates the
// parser registers in the cycle it is taken; the verdict is built from those
// registers in the cycle the marker is taken and is held in the output
// register, valid on rsp_chan in the next cycle.
// When rsp_chan stalls with a verdict held, req_ready drops until the
// verdict is taken; the output register is the only buffer.
// Reset clears the parser, the line counter and the output valid; the block
// is ready in the first cycle after reset is released.
module rover_command_line_checker #(
   parameter int INT_WIDTH  = 16,
   parameter int LINE_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rlc_req_if.sink   req_chan,
   rlc_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_START, ST_LETTERS, ST_SPACE, ST_INT, ST_POINT, ST_FRAC, ST_TAIL, ST_ERR
   } parse_state_type;

   localparam logic [INT_WIDTH-1:0] INT_MAX = '1;

   parse_state_type                   state_ff, state_in;
   logic [rlc_pkg::LC_WIDTH-1:0]      letter_count_ff, letter_count_in;
   logic [rlc_pkg::KW_NUM-1:0]        keyword_match_ff, keyword_match_in;
   logic                              sign_negative_ff, sign_negative_in;
   logic [INT_WIDTH-1:0]              integer_part_ff, integer_part_in;
   logic                              fraction_nonzero_ff, fraction_nonzero_in;
   logic                              digit_seen_ff, digit_seen_in;
   logic [LINE_WIDTH-1:0]             line_counter_ff, line_counter_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rlc_pkg::STATUS_WIDTH-1:0]  status_ff, status_in;
   logic [rlc_pkg::CMD_WIDTH-1:0]     command_ff, command_in;
   logic                              negative_ff, negative_in;
   logic [rlc_pkg::VALUE_WIDTH-1:0]   integer_ff, integer_in;
   logic                              has_fraction_ff, has_fraction_in;
   logic [rlc_pkg::VALUE_WIDTH-1:0]   line_number_ff, line_number_in;

   logic                              req_transfer;
   logic [rlc_pkg::CH_WIDTH-1:0]      ch;
   logic [INT_WIDTH+3:0]              int_times_ten;
   logic [INT_WIDTH-1:0]              int_next;
   logic [rlc_pkg::KW_NUM-1:0]        match_next;
   logic                              kw_found;
   logic [rlc_pkg::KW_IDX_WIDTH-1:0]  kw_sel;
   logic                              has_param;
   logic                              line_ok;
   logic                              in_range;
   logic                              mag_zero;
   logic [INT_WIDTH+rlc_pkg::VALUE_WIDTH-1:0]  int_wide;
   logic [LINE_WIDTH+rlc_pkg::VALUE_WIDTH-1:0] line_wide;

   function automatic logic mag_within(input logic [INT_WIDTH-1:0] mag,
                                       input logic frac,
                                       input logic [9:0] limit);
      logic [INT_WIDTH-1:0] lim;
      lim = INT_WIDTH'(limit);
      return (mag < lim) || (mag == lim && !frac);
   endfunction

   assign req_transfer   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign ch             = req_chan.ch;

   // saturating decimal accumulate: x*10 + digit
   always_comb begin
      int_times_ten = ({4'b0, integer_part_ff} << 3) + ({4'b0, integer_part_ff} << 1)
                      + (INT_WIDTH+4)'(ch[3:0]);
      if (int_times_ten[INT_WIDTH+3:INT_WIDTH] != 4'b0)
         int_next = INT_MAX;
      else
         int_next = int_times_ten[INT_WIDTH-1:0];
   end

   always_comb begin
      match_next = keyword_match_ff;
      for (int k = 0; k < rlc_pkg::KW_NUM; k++) begin
         if (letter_count_ff >= rlc_pkg::KW_LEN[k] ||
             rlc_pkg::kw_letter(rlc_pkg::KW_IDX_WIDTH'(k), letter_count_ff) != ch)
            match_next[k] = 1'b0;
      end
   end

   // verdict from the parser registers as they stand at the marker
   always_comb begin
      kw_found = 1'b0;
      kw_sel   = '0;
      for (int k = 0; k < rlc_pkg::KW_NUM; k++) begin
         if (!kw_found && keyword_match_ff[k] && letter_count_ff == rlc_pkg::KW_LEN[k]) begin
            kw_found = 1'b1;
            kw_sel   = rlc_pkg::KW_IDX_WIDTH'(k);
         end
      end
      has_param = state_ff == ST_FRAC || state_ff == ST_TAIL ||
                  (state_ff == ST_INT && digit_seen_ff);
      line_ok   = kw_found &&
                  (has_param || (state_ff == ST_LETTERS && kw_sel == rlc_pkg::CMD_PHOTO));
      mag_zero  = integer_part_ff == '0 && !fraction_nonzero_ff;
      case (kw_sel)
         rlc_pkg::CMD_WHEELS:
            in_range = mag_within(integer_part_ff, fraction_nonzero_ff, rlc_pkg::LIM_WHEELS);
         rlc_pkg::CMD_ARM_TURN:
            in_range = (!sign_negative_ff || mag_zero) &&
                       mag_within(integer_part_ff, fraction_nonzero_ff, rlc_pkg::LIM_ARM_TURN);
         rlc_pkg::CMD_MOVE:
            in_range = !mag_zero;
         rlc_pkg::CMD_ARM_EXTEND:
            in_range = (!sign_negative_ff || mag_zero) &&
                       mag_within(integer_part_ff, fraction_nonzero_ff,
                                  rlc_pkg::LIM_ARM_EXTEND);
         rlc_pkg::CMD_TILT:
            in_range = mag_within(integer_part_ff, fraction_nonzero_ff, rlc_pkg::LIM_TILT);
         default:
            in_range = 1'b1;
      endcase
   end

   assign int_wide  = {{rlc_pkg::VALUE_WIDTH{1'b0}}, integer_part_ff};
   assign line_wide = {{rlc_pkg::VALUE_WIDTH{1'b0}}, line_counter_in};

   always_comb begin
      state_in            = state_ff;
      letter_count_in     = letter_count_ff;
      keyword_match_in    = keyword_match_ff;
      sign_negative_in    = sign_negative_ff;
      integer_part_in     = integer_part_ff;
      fraction_nonzero_in = fraction_nonzero_ff;
      digit_seen_in       = digit_seen_ff;
      line_counter_in     = line_counter_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      status_in       = status_ff;
      command_in      = command_ff;
      negative_in     = negative_ff;
      integer_in      = integer_ff;
      has_fraction_in = has_fraction_ff;
      line_number_in  = line_number_ff;

      if (req_transfer && req_chan.line_end) begin
         line_counter_in = line_counter_ff + LINE_WIDTH'(1);
         rsp_valid_in    = 1'b1;
         if (line_ok)
            status_in = in_range ? rlc_pkg::STATUS_OK : rlc_pkg::STATUS_RANGE;
         else
            status_in = rlc_pkg::STATUS_SYNTAX;
         command_in      = line_ok ? kw_sel : '0;
         negative_in     = line_ok && sign_negative_ff;
         integer_in      = line_ok ? int_wide[rlc_pkg::VALUE_WIDTH-1:0] : '0;
         has_fraction_in = line_ok && fraction_nonzero_ff;
         line_number_in  = line_wide[rlc_pkg::VALUE_WIDTH-1:0];

         // start the next line
         state_in            = ST_START;
         letter_count_in     = '0;
         keyword_match_in    = '1;
         sign_negative_in    = 1'b0;
         integer_part_in     = '0;
         fraction_nonzero_in = 1'b0;
         digit_seen_in       = 1'b0;
      end else if (req_transfer) begin
         unique case (state_ff)
            ST_START, ST_LETTERS: begin
               if (rlc_pkg::is_letter(ch)) begin
                  keyword_match_in = match_next;
                  if (letter_count_ff != '1)
                     letter_count_in = letter_count_ff + rlc_pkg::LC_WIDTH'(1);
                  state_in = ST_LETTERS;
               end else if (state_ff == ST_LETTERS && ch == rlc_pkg::CH_SPACE) begin
                  state_in = ST_SPACE;
               end else begin
                  state_in = ST_ERR;
               end
            end
            ST_SPACE: begin
               if (rlc_pkg::is_digit(ch)) begin
                  integer_part_in = int_next;
                  digit_seen_in   = 1'b1;
                  state_in        = ST_INT;
               end else if (ch == rlc_pkg::CH_PLUS) begin
                  state_in = ST_INT;
               end else if (ch == rlc_pkg::CH_MINUS) begin
                  sign_negative_in = 1'b1;
                  state_in         = ST_INT;
               end else begin
                  state_in = ST_ERR;
               end
            end
            ST_INT: begin
               if (rlc_pkg::is_digit(ch)) begin
                  integer_part_in = int_next;
                  digit_seen_in   = 1'b1;
               end else begin
                  state_in = (ch == rlc_pkg::CH_POINT) ? ST_POINT : ST_ERR;
               end
            end
            ST_POINT, ST_FRAC: begin
               if (rlc_pkg::is_digit(ch)) begin
                  if (ch != 8'h30)
                     fraction_nonzero_in = 1'b1;
                  digit_seen_in = 1'b1;
                  state_in      = ST_FRAC;
               end else begin
                  // one trailing character after fraction digits is tolerated
                  state_in = (state_ff == ST_FRAC) ? ST_TAIL : ST_ERR;
               end
            end
            ST_TAIL, ST_ERR: begin
               state_in = ST_ERR;
            end
            default: begin
               state_in = ST_ERR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_START;
         letter_count_ff     <= '0;
         keyword_match_ff    <= '1;
         sign_negative_ff    <= 1'b0;
         integer_part_ff     <= '0;
         fraction_nonzero_ff <= 1'b0;
         digit_seen_ff       <= 1'b0;
         line_counter_ff     <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         letter_count_ff     <= letter_count_in;
         keyword_match_ff    <= keyword_match_in;
         sign_negative_ff    <= sign_negative_in;
         integer_part_ff     <= integer_part_in;
         fraction_nonzero_ff <= fraction_nonzero_in;
         digit_seen_ff       <= digit_seen_in;
         line_counter_ff     <= line_counter_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      status_ff       <= status_in;
      command_ff      <= command_in;
      negative_ff     <= negative_in;
      integer_ff      <= integer_in;
      has_fraction_ff <= has_fraction_in;
      line_number_ff  <= line_number_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = status_ff;
   assign rsp_chan.command            = command_ff;
   assign rsp_chan.param_negative     = negative_ff;
   assign rsp_chan.param_integer      = integer_ff;
   assign rsp_chan.param_has_fraction = has_fraction_ff;
   assign rsp_chan.line_number        = line_number_ff;

`ifndef NO_ASSERTIONS
   a_marker_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      req_transfer && req_chan.line_end |=> rsp_chan.valid)
      else $error("line end transfer did not produce a verdict");

   a_verdict_has_marker: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(req_transfer && req_chan.line_end))
      else $error("verdict appeared without a line end transfer");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == rlc_pkg::STATUS_SYNTAX |->
         rsp_chan.command == '0 && !rsp_chan.param_negative &&
         rsp_chan.param_integer == '0 && !rsp_chan.param_has_fraction)
      else $error("syntax error verdict carries parameter fields");

   a_parser_clear_after_marker: assert property (@(posedge clock) disable iff (reset)
      req_transfer && req_chan.line_end |=>
         state_ff == ST_START && letter_count_ff == '0 && keyword_match_ff == '1)
      else $error("parser not cleared after line end");
`endif

endmodule
